// File: sv/assert_macros.svh
// shared assertion macros, all sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// trigger implies property at the next clock edge
`define ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, prop)
`define ASSERT_NEXT(lbl, trig, prop)

`endif

`endif

// File: sv/lpwm_pkg.sv
package lpwm_pkg;

  // pattern geometry
  localparam int unsigned MAX_PATTERN_LEN = 48;
  localparam int unsigned LETTER_COUNT    = 26;
  localparam int unsigned CODE_BITS       = 5;
  localparam int unsigned CODES_PER_REG   = 12;
  localparam int unsigned LETTER_REG_BITS = CODE_BITS * CODES_PER_REG;
  localparam int unsigned PATTERN_BITS    = LETTER_REG_BITS * 4;
  localparam int unsigned COUNT_BITS      = 6;
  localparam int unsigned CFG_DATA_BITS   = 64;
  localparam int unsigned CFG_ADDR_BITS   = 6;

  // register indexes (byte address is 8 * index)
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [2:0] REG_LETTERS_0      = 3'd1;
  localparam logic [2:0] REG_LETTERS_1      = 3'd2;
  localparam logic [2:0] REG_LETTERS_2      = 3'd3;
  localparam logic [2:0] REG_LETTERS_3      = 3'd4;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CODE_BITS-1:0]  letter_t;
  typedef logic [7:0]            char_t;

endpackage

// File: sv/letter_pattern_word_matcher.sv
// letter pattern word matcher
// word bytes arrive on the input channel (word_byte_i, last_byte_i, valid/ready),
// one transaction per byte, the final byte of a word flagged by last_byte_i.
// each pattern letter is a variable: its first position binds it to the byte
// there, later positions must repeat that byte. one result transaction per word
// leaves on the output channel: word_matched_o and word_length_o (saturates at 63).
// the pattern is set over the apb port: pattern_length at 0x00, the four
// 60-bit letter registers (twelve 5-bit codes each) at 0x08, 0x10, 0x18, 0x20;
// write it only while no word is in flight.
// throughput: one byte per cycle, set by the single binding table lookup and
// compare stage that sits between the input register and the result register.
// a word's result is registered once its final byte leaves the input register.
// when the receiver stalls, the result register holds; the input register keeps
// filling with bytes that do not end a word, and a final byte waits there, so
// ready drops only once that register is blocked.
// reset clears the pattern, bindings, position count and conflict flag and
// empties both registers; the block takes transactions in the first cycle after.
`include "assert_macros.svh"

module letter_pattern_word_matcher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // byte stream
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lpwm_pkg::char_t                     word_byte_i,
  input  logic                                last_byte_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                word_matched_o,
  output lpwm_pkg::count_t                    word_length_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpwm_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [lpwm_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [lpwm_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                pready
);
  import lpwm_pkg::*;

  // configuration registers
  count_t                    plen_q;
  logic [PATTERN_BITS-1:0]   pattern_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  // input register
  logic                      s1_valid_q;
  char_t                     s1_byte_q;
  logic                      s1_last_q;
  logic                      s1_go;

  // per-word state
  char_t                     table_q [LETTER_COUNT];
  logic [LETTER_COUNT-1:0]   bvalid_q;
  logic [LETTER_COUNT-1:0]   bvalid_d;
  count_t                    count_q;
  count_t                    count_d;
  logic                      conflict_q;
  logic                      conflict_d;

  // result register
  logic                      out_valid_q;
  logic                      matched_q;
  count_t                    length_q;

  // lookup signals
  count_t                    pos_idx;
  logic                      in_pat;
  letter_t                   code;
  logic                      bad_code;
  letter_t                   code_idx;
  logic                      bound;
  logic                      mismatch;
  logic                      bind_en;
  logic                      conflict_step;
  count_t                    count_inc;
  logic                      matched;

  // apb decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[5:3];

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_PATTERN_LENGTH: prdata = CFG_DATA_BITS'(plen_q);
      REG_LETTERS_0: prdata = CFG_DATA_BITS'(pattern_q[0*LETTER_REG_BITS +: LETTER_REG_BITS]);
      REG_LETTERS_1: prdata = CFG_DATA_BITS'(pattern_q[1*LETTER_REG_BITS +: LETTER_REG_BITS]);
      REG_LETTERS_2: prdata = CFG_DATA_BITS'(pattern_q[2*LETTER_REG_BITS +: LETTER_REG_BITS]);
      REG_LETTERS_3: prdata = CFG_DATA_BITS'(pattern_q[3*LETTER_REG_BITS +: LETTER_REG_BITS]);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= '0;
      pattern_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_LENGTH: plen_q <= pwdata[COUNT_BITS-1:0];
        REG_LETTERS_0: pattern_q[0*LETTER_REG_BITS +: LETTER_REG_BITS] <=
                         pwdata[LETTER_REG_BITS-1:0];
        REG_LETTERS_1: pattern_q[1*LETTER_REG_BITS +: LETTER_REG_BITS] <=
                         pwdata[LETTER_REG_BITS-1:0];
        REG_LETTERS_2: pattern_q[2*LETTER_REG_BITS +: LETTER_REG_BITS] <=
                         pwdata[LETTER_REG_BITS-1:0];
        REG_LETTERS_3: pattern_q[3*LETTER_REG_BITS +: LETTER_REG_BITS] <=
                         pwdata[LETTER_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a final byte needs room in the result register
  assign s1_go      = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= word_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  // pattern letter at the current position
  always_comb begin
    in_pat   = (count_q < plen_q) && (count_q < COUNT_BITS'(MAX_PATTERN_LEN));
    pos_idx  = (count_q < COUNT_BITS'(MAX_PATTERN_LEN)) ? count_q : '0;
    code     = pattern_q[CODE_BITS*pos_idx +: CODE_BITS];
    bad_code = code >= CODE_BITS'(LETTER_COUNT);
    code_idx = bad_code ? '0 : code;
  end

  // binding lookup and compare
  always_comb begin
    bound         = bvalid_q[code_idx];
    mismatch      = bound && (table_q[code_idx] != s1_byte_q);
    bind_en       = in_pat && !bad_code && !bound;
    conflict_step = in_pat && (bad_code || mismatch);
    count_inc     = (count_q == '1) ? count_q : count_q + 1'b1;
    conflict_d    = conflict_q || conflict_step;
    matched       = (count_inc == plen_q) && (count_inc != '0) &&
                    (plen_q <= COUNT_BITS'(MAX_PATTERN_LEN)) && !conflict_d;
    bvalid_d      = bvalid_q;
    if (bind_en) begin
      bvalid_d[code_idx] = 1'b1;
    end
    count_d       = count_inc;
  end

  // per-word state, cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q   <= '0;
      count_q    <= '0;
      conflict_q <= 1'b0;
    end else if (s1_go) begin
      if (s1_last_q) begin
        bvalid_q   <= '0;
        count_q    <= '0;
        conflict_q <= 1'b0;
      end else begin
        bvalid_q   <= bvalid_d;
        count_q    <= count_d;
        conflict_q <= conflict_d;
      end
    end
  end

  // binding table, no reset: entries are read only once bound
  always_ff @(posedge clk_i) begin
    if (s1_go && bind_en) begin
      table_q[code_idx] <= s1_byte_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_last_q) begin
      matched_q <= matched;
      length_q  <= count_inc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_matched_o = matched_q;
  assign word_length_o  = length_q;

  // checks
  `ASSERT_ALWAYS(a_stall_only_when_full, in_ready_o || (s1_valid_q && s1_last_q && out_valid_q))
  `ASSERT_NEXT(a_word_end_clears, s1_go && s1_last_q,
               count_q == '0 && bvalid_q == '0 && !conflict_q)
  `ASSERT_NEXT(a_mid_word_counts, s1_go && !s1_last_q, count_q != '0)
  `ASSERT_ALWAYS(a_match_has_length,
                 !(out_valid_q && matched_q) || (length_q == plen_q && length_q != '0))

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import lpwm_pkg::*;

  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 533;

  // letter codes used by the directed patterns
  localparam letter_t LTR_A   = 5'd0;
  localparam letter_t LTR_B   = 5'd1;
  localparam letter_t LTR_Z   = 5'd25;
  localparam letter_t LTR_BAD = 5'd31;

  typedef struct packed {
    logic   matched;
    count_t length;
  } verdict_t;

  // tracks letter bindings per word and queues the verdict for each finished word
  class pattern_scoreboard;
    bit [COUNT_BITS-1:0]      pat_len;
    bit [LETTER_REG_BITS-1:0] letter_regs [4];
    bit [7:0]                 bind_byte [LETTER_COUNT];
    bit [LETTER_COUNT-1:0]    bind_valid;
    bit [COUNT_BITS-1:0]      pos;
    bit                       conflict;
    verdict_t                 verdict_q [$];
    int                       errors;

    function void write_reg(logic [2:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_PATTERN_LENGTH: pat_len = val[COUNT_BITS-1:0];
        REG_LETTERS_0, REG_LETTERS_1, REG_LETTERS_2, REG_LETTERS_3: begin
          letter_regs[idx - REG_LETTERS_0] = val[LETTER_REG_BITS-1:0];
        end
        default: ;
      endcase
    endfunction

    function void note_byte(char_t ch, logic last);
      int unsigned p;
      letter_t     code;
      bit          ok;
      p = pos;
      // only positions inside the pattern are looked up
      if (p < pat_len && p < MAX_PATTERN_LEN) begin
        code = letter_regs[p / CODES_PER_REG][(p % CODES_PER_REG) * CODE_BITS +: CODE_BITS];
        if (code >= LETTER_COUNT) begin
          conflict = 1'b1;
        end else if (bind_valid[code]) begin
          if (bind_byte[code] != ch) conflict = 1'b1;
        end else begin
          bind_byte[code]  = ch;
          bind_valid[code] = 1'b1;
        end
      end
      if (pos != COUNT_MAX) pos++;
      // word done: verdict, then clear for the next word
      if (last) begin
        ok = (pos == pat_len) && (pos != 0) && (pat_len <= MAX_PATTERN_LEN) && !conflict;
        verdict_q.push_back('{ok, pos});
        bind_valid = '0;
        pos        = '0;
        conflict   = 1'b0;
      end
    endfunction

    function void check_result(logic matched, count_t length);
      verdict_t e;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: matched %0b length %0d", $time, matched, length);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      if (matched !== e.matched) begin
        $display("%0t: word_matched mismatch: expected %0b actual %0b",
                 $time, e.matched, matched);
        errors++;
      end
      if (length !== e.length) begin
        $display("%0t: word_length mismatch: expected %0d actual %0d",
                 $time, e.length, length);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  char_t                    word_byte_i = '0;
  logic                     last_byte_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     word_matched_o;
  count_t                   word_length_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr       = '0;
  logic [CFG_DATA_BITS-1:0] pwdata      = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  pattern_scoreboard sb = new;

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          word_bytes  = 0;
  int unsigned cycle_count = 0;
  char_t       word_q [$];
  int          gen_len = 0;
  letter_t     gen_codes [MAX_PATTERN_LEN];

  letter_pattern_word_matcher DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .word_byte_i   (word_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_matched_o(word_matched_o),
    .word_length_o (word_length_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(word_matched_o, word_length_o);
  end

  // apb register write with setup and access phases, then the bus is left idle before returning
  task automatic apb_write(logic [2:0] idx, logic [CFG_DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // send the word held in word_q, one transaction per byte
  task automatic send_word();
    int i;
    for (i = 0; i < word_q.size(); i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      word_byte_i <= word_q[i];
      last_byte_i <= (i == word_q.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
      sb.note_byte(word_q[i], i == word_q.size() - 1);
    end
    word_bytes += word_q.size();
  endtask

  // hold off the sender until every verdict is back and the pipe is empty
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly random nonzero bytes, a small pool so distinct letters collide, rare zero
  function automatic char_t rand_byte();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 8'h00;
    if (r < 30) return 8'h41 + char_t'($urandom_range(0, 3));
    return char_t'($urandom_range(1, 255));
  endfunction

  // random pattern, mostly short, with extremes and bad codes now and then
  task automatic new_pattern();
    int                       len, k, base, p, r;
    bit                       bad, all_ones;
    letter_t                  code;
    logic [CFG_DATA_BITS-1:0] regs [4];
    drain();
    r = $urandom_range(99);
    if (r < 60)      len = $urandom_range(1, 8);
    else if (r < 75) len = $urandom_range(9, 20);
    else if (r < 85) len = $urandom_range(21, MAX_PATTERN_LEN);
    else if (r < 90) len = MAX_PATTERN_LEN;
    else if (r < 95) len = $urandom_range(MAX_PATTERN_LEN + 1, COUNT_MAX);
    else             len = 0;
    k        = $urandom_range(1, $urandom_range(1, LETTER_COUNT));
    base     = $urandom_range(0, LETTER_COUNT - 1);
    bad      = ($urandom_range(0, 9) == 0);
    all_ones = ($urandom_range(0, 24) == 0);
    for (p = 0; p < 4; p++) regs[p] = '0;
    for (p = 0; p < MAX_PATTERN_LEN; p++) begin
      if (all_ones) begin
        code = '1;
      end else if (p < len) begin
        code = letter_t'((base + $urandom_range(0, k - 1)) % LETTER_COUNT);
        if (bad && $urandom_range(0, 15) == 0) code = letter_t'($urandom_range(LETTER_COUNT, 31));
      end else begin
        code = letter_t'($urandom_range(0, 31));
      end
      gen_codes[p] = code;
      regs[p / CODES_PER_REG][(p % CODES_PER_REG) * CODE_BITS +: CODE_BITS] = code;
    end
    gen_len = len;
    apb_write(REG_PATTERN_LENGTH, CFG_DATA_BITS'(len));
    apb_write(REG_LETTERS_0, regs[0]);
    apb_write(REG_LETTERS_1, regs[1]);
    apb_write(REG_LETTERS_2, regs[2]);
    apb_write(REG_LETTERS_3, regs[3]);
  endtask

  // word that mostly fits the pattern, else corrupted, off-length, random or very long
  task automatic make_word();
    int    kind, n, p, fit_len, delta;
    char_t bound [LETTER_COUNT];
    kind    = $urandom_range(99);
    fit_len = (gen_len >= 1 && gen_len <= MAX_PATTERN_LEN) ? gen_len : $urandom_range(1, 12);
    if (kind < 75) begin
      n = fit_len;
    end else if (kind < 85) begin
      delta = $urandom_range(1, 3);
      n = $urandom_range(0, 1) ? fit_len + delta : fit_len - delta;
      if (n < 1) n = 1;
    end else if (kind < 95) begin
      n = $urandom_range(1, 12);
    end else begin
      n = $urandom_range(COUNT_MAX - 3, COUNT_MAX + 7);
    end
    for (p = 0; p < LETTER_COUNT; p++) bound[p] = rand_byte();
    word_q.delete();
    for (p = 0; p < n; p++) begin
      if (kind < 85 && p < gen_len && p < MAX_PATTERN_LEN && gen_codes[p] < LETTER_COUNT)
        word_q.push_back(bound[gen_codes[p]]);
      else
        word_q.push_back(rand_byte());
    end
    // flip one byte of an otherwise fitting word
    if (kind >= 65 && kind < 75) begin
      p = $urandom_range(0, n - 1);
      word_q[p] = word_q[p] ^ char_t'($urandom_range(1, 255));
    end
  endtask

  // stimulus
  initial begin
    int ph, phase_start, budget, cfg_start;
    tx_idle_pct = 25;
    rx_idle_pct = 62;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pattern length zero after reset matches nothing
    word_q = '{8'h5A};
    send_word();

    // pattern "aba": zero and all-ones bytes, shared bytes, conflict, long, short
    drain();
    apb_write(REG_PATTERN_LENGTH, CFG_DATA_BITS'(3));
    apb_write(REG_LETTERS_0, {49'b0, LTR_A, LTR_B, LTR_A});
    word_q = '{8'h00, 8'hFF, 8'h00};
    send_word();
    word_q = '{8'h41, 8'h41, 8'h41};
    send_word();
    word_q = '{8'h01, 8'h02, 8'h03};
    send_word();
    word_q = '{8'h05, 8'h06, 8'h05, 8'h07};
    send_word();
    word_q = '{8'h09, 8'h09};
    send_word();

    // bad letter code at the second position
    drain();
    apb_write(REG_PATTERN_LENGTH, CFG_DATA_BITS'(2));
    apb_write(REG_LETTERS_0, {54'b0, LTR_BAD, LTR_Z});
    word_q = '{8'h80, 8'h7F};
    send_word();

    // pattern length above the maximum
    drain();
    apb_write(REG_PATTERN_LENGTH, CFG_DATA_BITS'(MAX_PATTERN_LEN + 1));
    word_q = '{8'h33};
    send_word();

    // random phases with different idling profiles
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 25;
          rx_idle_pct = 62;
        end
        1: begin
          tx_idle_pct = 62;
          rx_idle_pct = 25;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_start = word_bytes;
      while (word_bytes - phase_start < PHASE_BYTES) begin
        new_pattern();
        budget    = $urandom_range(40, 90);
        cfg_start = word_bytes;
        while (word_bytes - cfg_start < budget) begin
          make_word();
          send_word();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/lpwm_pkg.sv
sv/letter_pattern_word_matcher.sv
dv/tb.sv
